@@ hdl/ldbe_pkg.sv @@
// package: payload structs, queue types, register indexes and reset values
package ldbe_pkg;

	localparam int unsigned ButtonCount = 7;

	typedef struct packed {
		logic [11:0] first_ladder_sample;
		logic [11:0] second_ladder_sample;
		logic        power_pin_level;
		logic [31:0] time_ms;
	} poll_t;

	typedef struct packed {
		logic [2:0] button_index;
		logic       is_press;
		logic       last_event;
		logic [6:0] stable_buttons;
	} event_t;

	typedef struct packed {
		logic [6:0] changed;
		logic [6:0] raw;
	} job_t;

	typedef struct packed {
		logic not_empty;
		logic full;
	} queue_status_t;

	localparam logic [2:0] RegNoButtonLevel  = 3'd0;
	localparam logic [2:0] RegFirstBoundA    = 3'd1;
	localparam logic [2:0] RegFirstBoundB    = 3'd2;
	localparam logic [2:0] RegFirstBoundC    = 3'd3;
	localparam logic [2:0] RegSecondBound    = 3'd4;
	localparam logic [2:0] RegDebounceDelay  = 3'd5;

	localparam logic [11:0] RstNoButtonLevel = 12'd3900;
	localparam logic [11:0] RstFirstBoundA   = 12'd3100;
	localparam logic [11:0] RstFirstBoundB   = 12'd2090;
	localparam logic [11:0] RstFirstBoundC   = 12'd750;
	localparam logic [11:0] RstSecondBound   = 12'd1120;
	localparam logic [15:0] RstDebounceDelay = 16'd5;

endpackage

@@ hdl/ladder_button_debounce_events.sv @@
// top level: ladder button debounce with press and release event output
//
//   channel  direction  handshake            payload
//   in       input      in_valid/in_stall    ldbe_pkg::poll_t
//   out      output     out_valid/out_stall  ldbe_pkg::event_t
//   cfg      input      cfg_we               cfg_index, cfg_data
//
// a poll is taken every cycle while the two-entry job queue has room
// a settled poll with changed buttons keeps the event engine busy loading its job
// and sending one event beat per changed button through the output register
// reset restores the register defaults and clears the debounce state
// out_stall holds the output register; the queue then absorbs two jobs
module ladder_button_debounce_events (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [2:0]       cfg_index,
	input  logic [15:0]      cfg_data,
	input  logic             in_valid,
	output logic             in_stall,
	input  ldbe_pkg::poll_t  in_data,
	output logic             out_valid,
	input  logic             out_stall,
	output ldbe_pkg::event_t out_data
);

	ldbe_pkg::queue_status_t q_status;
	ldbe_pkg::job_t          q_wdata;
	ldbe_pkg::job_t          q_rdata;
	logic                    q_push;
	logic                    q_pop;

	ldbe_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.q_status  (q_status),
		.q_push    (q_push),
		.q_wdata   (q_wdata)
	);

	ldbe_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.status (q_status)
	);

	ldbe_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_status  (q_status),
		.q_rdata   (q_rdata),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	a_push_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_status.full)
		else $error("job pushed into full queue");

	a_pop_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_status.not_empty)
		else $error("job popped from empty queue");

	a_event_index: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.button_index != 3'd7)
		else $error("event for nonexistent button");

	a_event_polarity: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.stable_buttons[out_data.button_index] == out_data.is_press)
		else $error("event polarity disagrees with stable bitmap");

endmodule

@@ hdl/ldbe_front.sv @@
// front end: config registers, ladder decode, debounce timer, job push
module ldbe_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [2:0]            cfg_index,
	input  logic [15:0]           cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  ldbe_pkg::poll_t       in_data,
	input  ldbe_pkg::queue_status_t q_status,
	output logic                  q_push,
	output ldbe_pkg::job_t        q_wdata
);

	logic [11:0] no_button_q;
	logic [11:0] bound_a_q;
	logic [11:0] bound_b_q;
	logic [11:0] bound_c_q;
	logic [11:0] bound_2_q;
	logic [15:0] delay_q;

	logic [6:0]  prev_raw_q;
	logic [31:0] change_time_q;
	logic [6:0]  debounced_q;

	logic        accept;
	logic [6:0]  raw;
	logic [31:0] ref_time;
	logic [31:0] elapsed;
	logic        settled;
	logic [6:0]  changed;
	logic [11:0] s1;
	logic [11:0] s2;

	assign s1 = in_data.first_ladder_sample;
	assign s2 = in_data.second_ladder_sample;

	always_comb begin
		raw = '0;
		priority if (s1 <= no_button_q && s1 > bound_a_q) begin
			raw[0] = 1'b1;
		end else if (s1 <= bound_a_q && s1 > bound_b_q) begin
			raw[1] = 1'b1;
		end else if (s1 <= bound_b_q && s1 > bound_c_q) begin
			raw[2] = 1'b1;
		end else if (s1 <= bound_c_q) begin
			raw[3] = 1'b1;
		end else begin
			raw[3:0] = 4'd0;
		end
		priority if (s2 <= no_button_q && s2 > bound_2_q) begin
			raw[4] = 1'b1;
		end else if (s2 <= bound_2_q) begin
			raw[5] = 1'b1;
		end else begin
			raw[5:4] = 2'd0;
		end
		raw[6] = ~in_data.power_pin_level;
	end

	assign in_stall = q_status.full;
	assign accept   = in_valid && !q_status.full;
	assign ref_time = (raw != prev_raw_q) ? in_data.time_ms : change_time_q;
	assign elapsed  = in_data.time_ms - ref_time;
	assign settled  = elapsed > {16'd0, delay_q};
	assign changed  = raw ^ debounced_q;

	assign q_push          = accept && settled && (changed != '0);
	assign q_wdata.changed = changed;
	assign q_wdata.raw     = raw;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			no_button_q   <= ldbe_pkg::RstNoButtonLevel;
			bound_a_q     <= ldbe_pkg::RstFirstBoundA;
			bound_b_q     <= ldbe_pkg::RstFirstBoundB;
			bound_c_q     <= ldbe_pkg::RstFirstBoundC;
			bound_2_q     <= ldbe_pkg::RstSecondBound;
			delay_q       <= ldbe_pkg::RstDebounceDelay;
			prev_raw_q    <= '0;
			change_time_q <= '0;
			debounced_q   <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					ldbe_pkg::RegNoButtonLevel: no_button_q <= cfg_data[11:0];
					ldbe_pkg::RegFirstBoundA:   bound_a_q   <= cfg_data[11:0];
					ldbe_pkg::RegFirstBoundB:   bound_b_q   <= cfg_data[11:0];
					ldbe_pkg::RegFirstBoundC:   bound_c_q   <= cfg_data[11:0];
					ldbe_pkg::RegSecondBound:   bound_2_q   <= cfg_data[11:0];
					ldbe_pkg::RegDebounceDelay: delay_q     <= cfg_data;
					default: ;
				endcase
			end
			if (accept) begin
				prev_raw_q    <= raw;
				change_time_q <= ref_time;
			end
			if (q_push) begin
				debounced_q <= raw;
			end
		end
	end

endmodule

@@ hdl/ldbe_queue.sv @@
// two-entry job queue between front and back
module ldbe_queue (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  ldbe_pkg::job_t          wdata,
	input  logic                    pop,
	output ldbe_pkg::job_t          rdata,
	output ldbe_pkg::queue_status_t status
);

	ldbe_pkg::job_t mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign rdata            = mem_q[rd_ptr_q];
	assign status.not_empty = count_q != 2'd0;
	assign status.full      = count_q == 2'd2;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ hdl/ldbe_back.sv @@
// back end: turns each job into per-button event beats
module ldbe_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  ldbe_pkg::queue_status_t q_status,
	input  ldbe_pkg::job_t          q_rdata,
	output logic                    q_pop,
	output logic                    out_valid,
	input  logic                    out_stall,
	output ldbe_pkg::event_t        out_data
);

	logic             busy_q;
	logic [6:0]       rem_q;
	logic [6:0]       raw_q;
	logic             out_valid_q;
	ldbe_pkg::event_t out_data_q;

	logic       slot_free;
	logic       emit;
	logic [6:0] low_bit;
	logic [6:0] rem_next;
	logic [2:0] idx;

	assign slot_free = !out_valid_q || !out_stall;
	assign q_pop     = !busy_q && q_status.not_empty;
	assign emit      = busy_q && slot_free;
	assign low_bit   = rem_q & (~rem_q + 7'd1);
	assign rem_next  = rem_q & ~low_bit;

	always_comb begin
		idx = '0;
		for (int i = ldbe_pkg::ButtonCount - 1; i >= 0; i--) begin
			if (rem_q[i]) begin
				idx = 3'(i);
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_ff @(posedge clk) begin
		if (q_pop) begin
			raw_q <= q_rdata.raw;
		end
		if (emit) begin
			out_data_q.button_index   <= idx;
			out_data_q.is_press       <= raw_q[idx];
			out_data_q.last_event     <= rem_next == '0;
			out_data_q.stable_buttons <= raw_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			rem_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				busy_q <= 1'b1;
				rem_q  <= q_rdata.changed;
			end else if (emit) begin
				rem_q <= rem_next;
				if (rem_next == '0) begin
					busy_q <= 1'b0;
				end
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

@@ test/tb_ladder_button_debounce_events.sv @@
// testbench: ladder button debounce, predicted press and release events checked beat by beat
`timescale 1ns / 100ps

module tb_ladder_button_debounce_events;

	typedef enum int {ShapeDefault, ShapeSorted, ShapeUnsorted, ShapeSlow} cfg_shape_t;

	localparam logic [2:0] RegUnusedLow  = 3'd6;
	localparam logic [2:0] RegUnusedHigh = 3'd7;
	localparam int unsigned ItemsPerPhase = 86;
	localparam int unsigned SettleCycles  = 20;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_we = 1'b0;
	logic [2:0]        cfg_index = '0;
	logic [15:0]       cfg_data = '0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	ldbe_pkg::poll_t   in_data = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	ldbe_pkg::event_t  out_data;

	logic [11:0] no_button_level = ldbe_pkg::RstNoButtonLevel;
	logic [11:0] bound_a = ldbe_pkg::RstFirstBoundA;
	logic [11:0] bound_b = ldbe_pkg::RstFirstBoundB;
	logic [11:0] bound_c = ldbe_pkg::RstFirstBoundC;
	logic [11:0] second_bound = ldbe_pkg::RstSecondBound;
	logic [15:0] delay_ms = ldbe_pkg::RstDebounceDelay;

	logic [6:0]  raw_prev = '0;
	logic [31:0] change_at = '0;
	logic [6:0]  stable_now = '0;

	logic [31:0]      now_ms = '0;
	ldbe_pkg::event_t pending_events[$];
	int unsigned      errors = 0;
	bit               quiet_in = 1'b0;
	bit               quiet_out = 1'b0;

	ladder_button_debounce_events uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

	always #5 clk = ~clk;

	initial begin
		#10_000_000;
		$display("FAIL");
		$finish;
	end

	function automatic logic [6:0] ladder_state(input logic [11:0] s1, input logic [11:0] s2,
			input logic pin);
		logic [6:0] r;
		r = '0;
		if (s1 <= no_button_level && s1 > bound_a) r[0] = 1'b1;
		else if (s1 <= bound_a && s1 > bound_b) r[1] = 1'b1;
		else if (s1 <= bound_b && s1 > bound_c) r[2] = 1'b1;
		else if (s1 <= bound_c) r[3] = 1'b1;
		if (s2 <= no_button_level && s2 > second_bound) r[4] = 1'b1;
		else if (s2 <= second_bound) r[5] = 1'b1;
		if (!pin) r[6] = 1'b1;
		return r;
	endfunction

	function automatic void predict_events(input ldbe_pkg::poll_t p);
		logic [6:0]       raw;
		logic [6:0]       changed;
		logic [31:0]      elapsed;
		int               last_bit;
		ldbe_pkg::event_t ev;
		raw = ladder_state(p.first_ladder_sample, p.second_ladder_sample, p.power_pin_level);
		if (raw != raw_prev) begin
			change_at = p.time_ms;
			raw_prev = raw;
		end
		elapsed = p.time_ms - change_at;
		if (elapsed <= {16'd0, delay_ms}) return;
		changed = raw ^ stable_now;
		if (changed == '0) return;
		last_bit = 0;
		for (int i = 0; i < ldbe_pkg::ButtonCount; i++)
			if (changed[i]) last_bit = i;
		for (int i = 0; i < ldbe_pkg::ButtonCount; i++) begin
			if (changed[i]) begin
				ev.button_index = 3'(i);
				ev.is_press = raw[i];
				ev.last_event = (i == last_bit);
				ev.stable_buttons = raw;
				pending_events.push_back(ev);
			end
		end
		stable_now = raw;
	endfunction

	function automatic int unsigned pick_run();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60) return $urandom_range(1, 3);
		if (r < 90) return $urandom_range(4, 10);
		return $urandom_range(20, 50);
	endfunction

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (quiet_in || r < 50) return 0;
		return pick_run();
	endfunction

	function automatic logic [11:0] pick_sample();
		logic [11:0] edges[5];
		edges = '{no_button_level, bound_a, bound_b, bound_c, second_bound};
		case ($urandom_range(0, 5))
			0, 1: return 12'($urandom_range(0, 4095));
			2: return 12'($urandom_range(0, 1) ? 4095 : 0);
			default: return edges[$urandom_range(0, 4)] + 12'($urandom_range(0, 2)) - 12'd1;
		endcase
	endfunction

	task automatic check_field(input string name, input int unsigned want, input int unsigned got);
		if (want != got) begin
			errors++;
			$display("%0t %s mismatch: expected %0d actual %0d", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin
		ldbe_pkg::event_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_events.size() == 0) begin
				errors++;
				$display("%0t unexpected event beat: expected none actual %h", $time, out_data);
			end else begin
				want = pending_events.pop_front();
				check_field("button_index", want.button_index, out_data.button_index);
				check_field("is_press", want.is_press, out_data.is_press);
				check_field("last_event", want.last_event, out_data.last_event);
				check_field("stable_buttons", want.stable_buttons, out_data.stable_buttons);
			end
		end
	end

	initial begin
		forever begin
			out_stall <= 1'b0;
			repeat (pick_run()) @(posedge clk);
			if (!quiet_out) begin
				out_stall <= 1'b1;
				repeat (pick_run()) @(posedge clk);
			end
		end
	end

	task automatic send_poll(input logic [11:0] s1, input logic [11:0] s2, input logic pin,
			input logic [31:0] t);
		ldbe_pkg::poll_t p;
		int unsigned     gap;
		p.first_ladder_sample = s1;
		p.second_ladder_sample = s2;
		p.power_pin_level = pin;
		p.time_ms = t;
		in_valid <= 1'b1;
		in_data <= p;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_events(p);
		gap = pick_gap();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_events.size() != 0) @(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			ldbe_pkg::RegNoButtonLevel: no_button_level = val[11:0];
			ldbe_pkg::RegFirstBoundA: bound_a = val[11:0];
			ldbe_pkg::RegFirstBoundB: bound_b = val[11:0];
			ldbe_pkg::RegFirstBoundC: bound_c = val[11:0];
			ldbe_pkg::RegSecondBound: second_bound = val[11:0];
			ldbe_pkg::RegDebounceDelay: delay_ms = val;
			default: ;
		endcase
	endtask

	task automatic configure(input logic [11:0] nbl, input logic [11:0] a, input logic [11:0] b,
			input logic [11:0] c, input logic [11:0] sb, input logic [15:0] dly);
		drain();
		// upper nibble is junk on the 12-bit registers
		write_reg(ldbe_pkg::RegNoButtonLevel, {4'($urandom_range(0, 15)), nbl});
		write_reg(ldbe_pkg::RegFirstBoundA, {4'($urandom_range(0, 15)), a});
		write_reg(ldbe_pkg::RegFirstBoundB, {4'($urandom_range(0, 15)), b});
		write_reg(ldbe_pkg::RegFirstBoundC, {4'($urandom_range(0, 15)), c});
		write_reg(ldbe_pkg::RegSecondBound, {4'($urandom_range(0, 15)), sb});
		write_reg(ldbe_pkg::RegDebounceDelay, dly);
		write_reg($urandom_range(0, 1) ? RegUnusedLow : RegUnusedHigh, 16'($urandom()));
		cfg_we <= 1'b0;
	endtask

	task automatic hold_buttons(input logic [11:0] s1, input logic [11:0] s2, input logic pin);
		send_poll(s1, s2, pin, now_ms);
		now_ms += {16'd0, delay_ms} + 32'd1;
		send_poll(s1, s2, pin, now_ms);
	endtask

	task automatic test_reset_bands();
		send_poll(12'd4095, 12'd4095, 1'b1, now_ms);
		hold_buttons(12'd3900, 12'd3901, 1'b1);
		hold_buttons(12'd3100, 12'd1121, 1'b0);
		hold_buttons(12'd751, 12'd1120, 1'b1);
		hold_buttons(12'd750, 12'd0, 1'b0);
		hold_buttons(12'd3901, 12'd3900, 1'b1);
		hold_buttons(12'd2090, 12'd4095, 1'b1);
	endtask

	task automatic test_time_wrap();
		now_ms = 32'hFFFF_FFFE;
		send_poll(12'd0, 12'd0, 1'b0, now_ms);
		send_poll(12'd0, 12'd0, 1'b0, 32'd3);
		send_poll(12'd0, 12'd0, 1'b0, 32'd4);
		// time going backwards wraps to a huge difference
		send_poll(12'd3101, 12'd2000, 1'b1, 32'd4);
		now_ms = 32'd1;
		send_poll(12'd3101, 12'd2000, 1'b1, now_ms);
	endtask

	task automatic test_register_extremes();
		configure(12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 16'd0);
		hold_buttons(12'd0, 12'd0, 1'b1);
		hold_buttons(12'd1, 12'd1, 1'b1);
		configure(12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 16'd65535);
		hold_buttons(12'd4095, 12'd4095, 1'b0);
		configure(12'd1000, 12'd3000, 12'd100, 12'd2000, 12'd4095, 16'd2);
		hold_buttons(12'd2500, 12'd500, 1'b1);
		hold_buttons(12'd50, 12'd4000, 1'b0);
	endtask

	task automatic random_config(input cfg_shape_t shape);
		int unsigned lv[$];
		logic [15:0] dly;
		logic [11:0] sb;
		repeat (4) lv.push_back($urandom_range(0, 4095));
		if (shape != ShapeUnsorted) lv.rsort();
		case (shape)
			ShapeSorted: dly = 16'($urandom_range(0, 3));
			ShapeUnsorted: dly = 16'($urandom_range(0, 20));
			default: dly = 16'($urandom_range(1000, 65535));
		endcase
		sb = (shape == ShapeUnsorted) ? 12'($urandom_range(0, 4095)) : 12'($urandom_range(0, lv[0]));
		if (shape == ShapeDefault)
			configure(ldbe_pkg::RstNoButtonLevel, ldbe_pkg::RstFirstBoundA,
				ldbe_pkg::RstFirstBoundB, ldbe_pkg::RstFirstBoundC,
				ldbe_pkg::RstSecondBound, ldbe_pkg::RstDebounceDelay);
		else
			configure(12'(lv[0]), 12'(lv[1]), 12'(lv[2]), 12'(lv[3]), sb, dly);
	endtask

	task automatic run_sequence(inout int unsigned count);
		logic [11:0] s1;
		logic [11:0] s2;
		logic        pin;
		logic [31:0] start;
		int unsigned step;
		int unsigned r;
		step = delay_ms / 3 + 1;
		r = $urandom_range(0, 9);
		if (r == 0) now_ms = $urandom();
		// noise: one to four random polls, each up to about two debounce windows after the last
		if (r == 1) begin
			repeat ($urandom_range(1, 4)) begin
				now_ms += $urandom_range(0, 2 * delay_ms + 2);
				send_poll(pick_sample(), pick_sample(), 1'($urandom_range(0, 1)), now_ms);
				count++;
			end
			return;
		end
		repeat ($urandom_range(0, 3)) begin
			now_ms += $urandom_range(0, step);
			send_poll(pick_sample(), pick_sample(), 1'($urandom_range(0, 1)), now_ms);
			count++;
		end
		s1 = pick_sample();
		s2 = pick_sample();
		pin = 1'($urandom_range(0, 1));
		start = now_ms;
		send_poll(s1, s2, pin, now_ms);
		count++;
		while (now_ms - start <= {16'd0, delay_ms}) begin
			now_ms += $urandom_range(1, step);
			send_poll(s1, s2, pin, now_ms);
			count++;
		end
	endtask

	task automatic test_random_polls();
		cfg_shape_t  shapes[5];
		int unsigned count;
		shapes = '{ShapeDefault, ShapeSorted, ShapeUnsorted, ShapeSlow, ShapeSorted};
		for (int ph = 0; ph < 5; ph++) begin
			random_config(shapes[ph]);
			quiet_in = (ph == 1);
			quiet_out = (ph == 1);
			count = 0;
			while (count < ItemsPerPhase) run_sequence(count);
		end
		quiet_in = 1'b0;
		quiet_out = 1'b0;
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_bands();
		test_time_wrap();
		test_register_extremes();
		test_random_polls();
		drain();
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
